### hdl/yiq_pixel_diff_counter_unit_assert.svh
`ifndef YIQ_PIXEL_DIFF_COUNTER_UNIT_ASSERT_SVH
`define YIQ_PIXEL_DIFF_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication, checked from the clock edge, off during reset
`define YPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define YPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ypd_pkg.sv
package ypd_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_COUNT_W     = 32;
  localparam int REG_W           = 32;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_ENABLE = 2'd2;

  localparam int D_W     = 18;  // |D| <= 65025
  localparam int COEF_W  = 16;
  localparam int INNER_W = D_W + COEF_W;
  localparam int PROD_W  = D_W + INNER_W;
  localparam int LIMIT_W = 48;

  localparam logic [15:0] LIMIT_SCALE = 16'd65025;

  // YIQ weights, signed Q0.16
  localparam logic signed [COEF_W-1:0] K_RR = 16'sd10492;
  localparam logic signed [COEF_W-1:0] K_RG = 16'sd2374;
  localparam logic signed [COEF_W-1:0] K_RB = -16'sd3562;
  localparam logic signed [COEF_W-1:0] K_GG = 16'sd16372;
  localparam logic signed [COEF_W-1:0] K_GB = 16'sd3735;
  localparam logic signed [COEF_W-1:0] K_BB = 16'sd3705;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic differs;
    logic last;
  } cls_t;

  typedef struct packed {
    logic [REG_W-1:0] color;
    logic             enable;
  } mark_cfg_t;

endpackage

### hdl/ypd_front.sv
`include "yiq_pixel_diff_counter_unit_assert.svh"

module ypd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [31:0]                  pixel_a,
  input  logic [31:0]                  pixel_b,
  input  logic                         image_end,
  input  logic [ypd_pkg::LIMIT_W-1:0]  limit,
  output logic                         push,
  output ypd_pkg::cls_t                push_word,
  input  logic                         queue_full
);

  localparam int DW = ypd_pkg::D_W;
  localparam int IW = ypd_pkg::INNER_W;
  localparam int PW = ypd_pkg::PROD_W;
  localparam int FW = PW + 2;

  // 255 * D_blend, exact, in two's complement wraparound
  function automatic logic signed [DW-1:0] chan_delta(
    input logic [7:0] ca, input logic [7:0] cb,
    input logic [7:0] aa, input logic [7:0] ab);
    logic [15:0] pa;
    logic [15:0] pb;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [DW-1:0] d;
    pa = {8'h00, ca} * {8'h00, aa};
    pb = {8'h00, cb} * {8'h00, ab};
    wa = {aa, 8'h00} - {8'h00, aa};
    wb = {ab, 8'h00} - {8'h00, ab};
    d = {2'b00, pa} - {2'b00, pb} - {2'b00, wa} + {2'b00, wb};
    return $signed(d);
  endfunction

  logic en;
  logic v1, v2, v3, v4;

  logic signed [DW-1:0] d1_r, d1_g, d1_b;
  logic signed [DW-1:0] d2_r, d2_g, d2_b;
  logic signed [IW-1:0] in_r, in_g, in_b;
  logic signed [PW-1:0] pr_r, pr_g, pr_b;
  logic                 last1, last2, last3, last4;
  logic                 differs4;

  logic signed [IW-1:0] m_rr, m_rg, m_rb, m_gg, m_gb, m_bb;
  logic signed [PW-1:0] p_r, p_g, p_b;
  logic signed [FW-1:0] form;
  logic signed [FW-1:0] lim_s;

  assign en       = !v4 || !queue_full;
  assign in_ready = en;
  assign push     = v4 && !queue_full;
  assign push_word.differs = differs4;
  assign push_word.last    = last4;

  always_comb begin
    m_rr = IW'(d1_r) * IW'(ypd_pkg::K_RR);
    m_rg = IW'(d1_g) * IW'(ypd_pkg::K_RG);
    m_rb = IW'(d1_b) * IW'(ypd_pkg::K_RB);
    m_gg = IW'(d1_g) * IW'(ypd_pkg::K_GG);
    m_gb = IW'(d1_b) * IW'(ypd_pkg::K_GB);
    m_bb = IW'(d1_b) * IW'(ypd_pkg::K_BB);
    p_r  = PW'(d2_r) * PW'(in_r);
    p_g  = PW'(d2_g) * PW'(in_g);
    p_b  = PW'(d2_b) * PW'(in_b);
    form = FW'(pr_r) + FW'(pr_g) + FW'(pr_b);
    lim_s = $signed({{(FW - ypd_pkg::LIMIT_W){1'b0}}, limit});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r  <= chan_delta(pixel_a[7:0],   pixel_b[7:0],   pixel_a[31:24], pixel_b[31:24]);
      d1_g  <= chan_delta(pixel_a[15:8],  pixel_b[15:8],  pixel_a[31:24], pixel_b[31:24]);
      d1_b  <= chan_delta(pixel_a[23:16], pixel_b[23:16], pixel_a[31:24], pixel_b[31:24]);
      last1 <= image_end;

      in_r  <= m_rr + m_rg + m_rb;
      in_g  <= m_gg + m_gb;
      in_b  <= m_bb;
      d2_r  <= d1_r;
      d2_g  <= d1_g;
      d2_b  <= d1_b;
      last2 <= last1;

      pr_r  <= p_r;
      pr_g  <= p_g;
      pr_b  <= p_b;
      last3 <= last2;

      differs4 <= form > lim_s;
      last4    <= last3;
    end
  end

  // a classified word waiting on a full queue must not move
  `YPD_ASSERT_NEXT(a_stall_hold, clk, rst, v4 && queue_full, v4 && $stable(push_word), "front word changed while stalled")

endmodule

### hdl/ypd_fifo.sv
`include "yiq_pixel_diff_counter_unit_assert.svh"

module ypd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ypd_pkg::cls_t push_word,
  output logic          full,
  input  logic          pop,
  output ypd_pkg::cls_t head,
  output logic          empty
);

  localparam int DEPTH = ypd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  ypd_pkg::cls_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   cnt;

  assign full  = cnt == (PTR_W + 1)'(DEPTH);
  assign empty = cnt == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  `YPD_ASSERT_NOW(a_fill_range, clk, rst, 1'b1, cnt <= (PTR_W + 1)'(DEPTH), "queue fill out of range")

endmodule

### hdl/ypd_back.sv
`include "yiq_pixel_diff_counter_unit_assert.svh"

module ypd_back #(
  parameter int COUNT_WIDTH = ypd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ypd_pkg::cls_t                   head,
  input  logic                            empty,
  output logic                            pop,
  input  ypd_pkg::mark_cfg_t              mark_cfg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            is_different,
  output logic                            write_mark,
  output logic [ypd_pkg::REG_W-1:0]       mark_color,
  output logic [ypd_pkg::OUT_COUNT_W-1:0] diff_count,
  output logic                            count_final
);

  localparam int OW = ypd_pkg::OUT_COUNT_W;

  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [OW-1:0]          shown;
  logic                   mark;

  assign pop  = !empty && (!out_valid || out_ready);
  assign mark = head.differs && mark_cfg.enable;

  always_comb begin
    cnt_inc = (head.differs && cnt != '1) ? cnt + 1'b1 : cnt;
    if (pop) begin
      cnt_next = head.last ? '0 : cnt_inc;
    end else begin
      cnt_next = cnt;
    end
  end

  generate
    if (COUNT_WIDTH > OW) begin : g_sat
      assign shown = (|cnt_inc[COUNT_WIDTH-1:OW]) ? '1 : cnt_inc[OW-1:0];
    end else begin : g_ext
      assign shown = OW'(cnt_inc);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_different <= head.differs;
      write_mark   <= mark;
      mark_color   <= mark ? mark_cfg.color : '0;
      diff_count   <= shown;
      count_final  <= head.last;
    end
  end

  `YPD_ASSERT_NOW(a_mark_needs_diff, clk, rst, out_valid && write_mark, is_different, "mark without difference")
  `YPD_ASSERT_NOW(a_diff_counted, clk, rst, out_valid && is_different, diff_count != '0, "differing word with zero count")

endmodule

### hdl/yiq_pixel_diff_counter_unit.sv
// YIQ pixel difference counter. Each input word carries a pixel pair (s_tdata: pixel_a in
// bits 31:0, pixel_b in 63:32, RGBA bytes red lowest) and tlast on the last pair of an
// image; each output word gives the difference flag, the mark flag and colour, the running
// count of differing pixels and tlast when that count is the image total. One word per
// clock is taken and delivered sustained while m_tready is high. A word passes four
// stages of the classifying pipeline (channel deltas, weighted sums, quadratic products,
// sum and threshold compare), a four-word queue and the output register. The rate is set
// by the front pipeline, moving every cycle while the queue has room, and by the back-part
// counter, retiring one queued word per cycle. No clearing pass after reset. The user
// writes configuration only while no word is in flight; this is not enforced.
module yiq_pixel_diff_counter_unit #(
  parameter int COUNT_WIDTH = ypd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // pixel_a, pixel_b
  input  logic                            s_tlast,   // image_end
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [71:0]                     m_tdata,   // is_different, write_mark, mark_color,
                                                     // diff_count, zero fill
  output logic                            m_tlast,   // count_final
  input  logic                            cfg_we,
  input  logic [ypd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ypd_pkg::REG_W-1:0]       cfg_data
);

  logic [ypd_pkg::REG_W-1:0]       delta_threshold;
  ypd_pkg::mark_cfg_t              mark_cfg;
  logic [ypd_pkg::LIMIT_W-1:0]     limit;

  logic                            push;
  ypd_pkg::cls_t                   push_word;
  logic                            full;
  logic                            pop;
  ypd_pkg::cls_t                   head;
  logic                            empty;

  logic                            is_different;
  logic                            write_mark;
  logic [ypd_pkg::REG_W-1:0]       mark_color;
  logic [ypd_pkg::OUT_COUNT_W-1:0] diff_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_threshold <= '0;
      mark_cfg        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ypd_pkg::REG_THRESHOLD:   delta_threshold <= cfg_data;
        ypd_pkg::REG_DIFF_COLOR:  mark_cfg.color  <= cfg_data;
        ypd_pkg::REG_MARK_ENABLE: mark_cfg.enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // threshold scaled to match the form on 255-times channel deltas
  always_ff @(posedge clk) begin
    limit <= ypd_pkg::LIMIT_W'(delta_threshold) * ypd_pkg::LIMIT_W'(ypd_pkg::LIMIT_SCALE);
  end

  ypd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .pixel_a    (s_tdata[31:0]),
    .pixel_b    (s_tdata[63:32]),
    .image_end  (s_tlast),
    .limit      (limit),
    .push       (push),
    .push_word  (push_word),
    .queue_full (full)
  );

  ypd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  ypd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .mark_cfg     (mark_cfg),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .is_different (is_different),
    .write_mark   (write_mark),
    .mark_color   (mark_color),
    .diff_count   (diff_count),
    .count_final  (m_tlast)
  );

  assign m_tdata = {6'b000000, diff_count, mark_color, write_mark, is_different};

endmodule
